FILE: src/rfs_pkg.sv
// ----------------------------------------------------------------------------
// rfs_pkg
// Shared types, constants and helpers of the RPSI feedback body serializer.
// ----------------------------------------------------------------------------
package rfs_pkg;

	localparam int PID_W      = 64;
	localparam int GRP_W      = 7;
	localparam int GCNT_W     = 4;
	localparam int IDX_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int PT_W       = 7;
	localparam int QUEUE_DEPTH = 2;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SENDER_SSRC  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEDIA_SSRC   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_TYPE = 2'd2;

	// Byte positions of the fixed part of the body
	localparam logic [IDX_W-1:0] POS_PB      = 5'd8;
	localparam logic [IDX_W-1:0] POS_PT      = 5'd9;
	localparam logic [IDX_W-1:0] POS_GROUPS  = 5'd10;
	localparam logic [IDX_W-1:0] POS_LAST_FIXED = 5'd9;

	localparam logic [GCNT_W-1:0] MAX_GROUPS = 4'd10;
	localparam logic [7:0]        CONT_FLAG  = 8'h80;

	// One classified item: identifier and number of 7-bit groups (1..10)
	typedef struct packed {
		logic [PID_W-1:0]  pid;
		logic [GCNT_W-1:0] groups;
	} job_t;

	// Configuration register file
	typedef struct packed {
		logic [CFG_DATA_W-1:0] sender_ssrc;
		logic [CFG_DATA_W-1:0] media_ssrc;
		logic [PT_W-1:0]       payload_type;
	} cfg_t;

	// Sequencer status seen by the top level
	typedef struct packed {
		logic             busy;
		logic [IDX_W-1:0] idx;
	} back_stat_t;

	// Pick 7-bit group j of the identifier; the top group holds only bit 63
	function automatic logic [GRP_W-1:0] get_group(input logic [PID_W-1:0] pid,
		input logic [GCNT_W-1:0] j);
		logic [GRP_W-1:0] g;
		g = '0;
		case (j)
			4'd0: g = pid[6:0];
			4'd1: g = pid[13:7];
			4'd2: g = pid[20:14];
			4'd3: g = pid[27:21];
			4'd4: g = pid[34:28];
			4'd5: g = pid[41:35];
			4'd6: g = pid[48:42];
			4'd7: g = pid[55:49];
			4'd8: g = pid[62:56];
			4'd9: g = {6'd0, pid[63]};
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

FILE: src/rfs_front.sv
// ----------------------------------------------------------------------------
// rfs_front
// Accepts identifiers, counts their 7-bit groups and queues them for the
// byte sequencer.
// ----------------------------------------------------------------------------
module rfs_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [rfs_pkg::PID_W-1:0] pic_ref,
	output logic                      job_valid,
	output rfs_pkg::job_t             job,
	input  logic                      job_take
);
	import rfs_pkg::*;

	job_t             mem_q [QUEUE_DEPTH];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic [GCNT_W-1:0] groups;
	logic             push_fire;

	// Count groups: highest nonzero group plus one, at least one
	always_comb begin
		groups = 4'd1;
		for (int g = 1; g < 10; g++) begin
			if (get_group(pic_ref, 4'(g)) != '0) begin
				groups = 4'(g + 1);
			end
		end
	end

	assign full      = (cnt_q == 2'(QUEUE_DEPTH));
	assign push_fire = push && !full;
	assign job_valid = (cnt_q != 2'd0);
	assign job       = mem_q[rd_ptr_q];

	// Store classified item
	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= '{pid: pic_ref, groups: groups};
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (job_take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push_fire && !job_take) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push_fire && job_take) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: src/rfs_back.sv
// ----------------------------------------------------------------------------
// rfs_back
// Byte sequencer: walks one queued item through the feedback body, one byte
// per cycle while there is room, into a two-entry result queue.
// ----------------------------------------------------------------------------
module rfs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  rfs_pkg::cfg_t      cfg,
	input  logic               job_valid,
	input  rfs_pkg::job_t      job,
	output logic               job_take,
	output rfs_pkg::back_stat_t stat,
	output logic               empty,
	input  logic               pop,
	output logic [7:0]         out_byte,
	output logic               last_byte
);
	import rfs_pkg::*;

	// Current item
	logic              busy_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  last_idx_q;
	logic [PID_W-1:0]  pid_q;
	logic [GCNT_W-1:0] groups_q;
	logic [1:0]        pad_q;

	// Result queue
	logic [8:0]        oq_q [QUEUE_DEPTH];
	logic              owr_q;
	logic              ord_q;
	logic [1:0]        ocnt_q;

	logic              pop_fire;
	logic              room;
	logic              emit;
	logic              at_end;
	logic [7:0]        byte_d;
	logic [IDX_W-1:0]  gi;
	logic [GCNT_W-1:0] gj;
	logic [1:0]        pad_d;

	assign pop_fire = pop && !empty;
	assign room     = (ocnt_q != 2'(QUEUE_DEPTH)) || pop_fire;
	assign emit     = busy_q && room;
	assign at_end   = (idx_q == last_idx_q);
	assign job_take = job_valid && (!busy_q || (emit && at_end));
	assign pad_d    = 2'(4'd2 - job.groups);
	assign stat     = '{busy: busy_q, idx: idx_q};

	// Select the byte at the current position
	always_comb begin
		gi     = idx_q - POS_GROUPS;
		gj     = groups_q - 4'd1 - gi[GCNT_W-1:0];
		byte_d = 8'd0;
		if (idx_q <= POS_LAST_FIXED) begin
			unique case (idx_q)
				5'd0:    byte_d = cfg.sender_ssrc[31:24];
				5'd1:    byte_d = cfg.sender_ssrc[23:16];
				5'd2:    byte_d = cfg.sender_ssrc[15:8];
				5'd3:    byte_d = cfg.sender_ssrc[7:0];
				5'd4:    byte_d = cfg.media_ssrc[31:24];
				5'd5:    byte_d = cfg.media_ssrc[23:16];
				5'd6:    byte_d = cfg.media_ssrc[15:8];
				5'd7:    byte_d = cfg.media_ssrc[7:0];
				POS_PB:  byte_d = {3'd0, pad_q, 3'd0};
				POS_PT:  byte_d = {1'b0, cfg.payload_type};
				default: byte_d = 8'd0;
			endcase
		end else if (gi < {1'b0, groups_q}) begin
			byte_d = ((gj != '0) ? CONT_FLAG : 8'd0) | {1'b0, get_group(pid_q, gj)};
		end
	end

	// Load item payload
	always_ff @(posedge clk) begin
		if (job_take) begin
			pid_q      <= job.pid;
			groups_q   <= job.groups;
			pad_q      <= pad_d;
			last_idx_q <= 5'(POS_LAST_FIXED + {1'b0, job.groups} + {3'd0, pad_d});
		end
	end

	// Advance through the body
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (job_take) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (emit) begin
			if (at_end) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 5'd1;
			end
		end
	end

	// Hold results until popped
	always_ff @(posedge clk) begin
		if (emit) begin
			oq_q[owr_q] <= {at_end, byte_d};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (emit) begin
				owr_q <= !owr_q;
			end
			if (pop_fire) begin
				ord_q <= !ord_q;
			end
			if (emit && !pop_fire) begin
				ocnt_q <= ocnt_q + 2'd1;
			end else if (!emit && pop_fire) begin
				ocnt_q <= ocnt_q - 2'd1;
			end
		end
	end

	assign empty     = (ocnt_q == 2'd0);
	assign out_byte  = oq_q[ord_q][7:0];
	assign last_byte = oq_q[ord_q][8];

endmodule

FILE: src/rpsi_fci_serializer_top.sv
// ----------------------------------------------------------------------------
// rpsi_fci_serializer_top
// RPSI feedback body serializer: one 64-bit picture identifier in, the
// feedback control information body out, one byte per transfer.
//
// Input channel: drive pic_ref and raise push; a transfer happens on a
// clock edge with push high and full low. Up to two identifiers are queued.
// Result channel: while empty is low, out_byte/last_byte show the oldest
// byte; a transfer happens on an edge with pop high. last_byte marks the
// final byte of each body. Each body is 12 to 20 bytes (10 fixed bytes,
// 1 to 10 identifier groups, 0 to 3 zero bytes of padding).
// An item moves from the input queue into the sequencer, which registers
// its bytes into the result queue at one byte per cycle while that queue
// has room; bodies follow each other with no gap while queued.
// Configuration: cfg_we writes cfg_wdata into register cfg_index
// (0 sender SSRC, 1 media SSRC, 2 payload type); write only while idle.
// Reset clears both queues and the registers. When the receiver stalls,
// the result queue fills and the sequencer holds; the input queue then
// fills and full rises.
// ----------------------------------------------------------------------------
module rpsi_fci_serializer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [rfs_pkg::PID_W-1:0]     pic_ref,
	output logic                          empty,
	input  logic                          pop,
	output logic [7:0]                    out_byte,
	output logic                          last_byte,
	input  logic                          cfg_we,
	input  logic [rfs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rfs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import rfs_pkg::*;

	cfg_t       cfg_q;
	job_t       job;
	logic       job_valid;
	logic       job_take;
	back_stat_t stat;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SENDER_SSRC:  cfg_q.sender_ssrc  <= cfg_wdata;
				REG_MEDIA_SSRC:   cfg_q.media_ssrc   <= cfg_wdata;
				REG_PAYLOAD_TYPE: cfg_q.payload_type <= cfg_wdata[PT_W-1:0];
				default: ;
			endcase
		end
	end

	rfs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.pic_ref    (pic_ref),
		.job_valid  (job_valid),
		.job        (job),
		.job_take   (job_take)
	);

	rfs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take),
		.stat      (stat),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);

	// A full input queue always offers an item to the sequencer
	a_full_offers: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> job_valid)
		else $error("input queue full but no item offered");

	// The sequencer only takes an item that is offered
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |-> job_valid)
		else $error("sequencer took from an empty queue");

	// A body never runs past twenty bytes
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> (stat.idx < 5'd20))
		else $error("sequencer position out of range");

	// Taking a new item restarts the body at its first byte
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |=> (stat.busy && stat.idx == '0))
		else $error("new item did not start at byte zero");

endmodule
